// ----- rtl/core/kmh_pkg.sv -----
// ----------------------------------------------------------------------------
// kmh_pkg
// Shared widths, operation and result codes, datapath select codes and the
// command and status bundles between the timer queue controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kmh_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int ID_COUNT_DEF = 1024;

    localparam int OP_W   = 3;
    localparam int ID_W   = 10;
    localparam int TMO_W  = 24;
    localparam int TIME_W = 48;
    localparam int KIND_W = 2;
    localparam int REM_W  = 25;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADJUST = 3'd1;
    localparam logic [OP_W-1:0] OP_FIRE   = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMAIN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_ID = 2'd2;

    localparam logic [TMO_W-1:0] REM_MAX = 24'hFFFFFF;

    // Heap read address select.
    localparam logic [2:0] HRD_SLOT   = 3'd0;
    localparam logic [2:0] HRD_LEFT   = 3'd1;
    localparam logic [2:0] HRD_RIGHT  = 3'd2;
    localparam logic [2:0] HRD_PARENT = 3'd3;
    localparam logic [2:0] HRD_LAST   = 3'd4;
    localparam logic [2:0] HRD_ROOT   = 3'd5;

    // Heap write data select.
    localparam logic [1:0] HWR_CHILD = 2'd0;
    localparam logic [1:0] HWR_RD    = 2'd1;
    localparam logic [1:0] HWR_MOV   = 2'd2;

    // Hole index load select.
    localparam logic [2:0] AT_SLOT   = 3'd0;
    localparam logic [2:0] AT_COUNT  = 3'd1;
    localparam logic [2:0] AT_ZERO   = 3'd2;
    localparam logic [2:0] AT_CHILD  = 3'd3;
    localparam logic [2:0] AT_PARENT = 3'd4;

    localparam logic MOV_NEW = 1'b0;
    localparam logic MOV_RD  = 1'b1;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_CLR  = 2'd3;

    // Result select.
    localparam logic [2:0] EM_ID_REQ   = 3'd0;
    localparam logic [2:0] EM_ID_RD    = 3'd1;
    localparam logic [2:0] EM_REM_RD   = 3'd2;
    localparam logic [2:0] EM_REM_NONE = 3'd3;
    localparam logic [2:0] EM_STATUS   = 3'd4;

    typedef struct packed {
        logic            latch;
        logic            hrd_en;
        logic [2:0]      hrd_sel;
        logic            hwr_en;
        logic [1:0]      hwr_sel;
        logic            at_ld;
        logic [2:0]      at_sel;
        logic            mov_ld;
        logic            mov_sel;
        logic [1:0]      cnt_op;
        logic            ca_ld;
        logic            cb_ld;
        logic            moved_clr;
        logic            moved_set;
        logic            emit;
        logic [2:0]      emit_sel;
        logic [ST_W-1:0] emit_status;
        logic            emit_last;
    } t_cmd;

    typedef struct packed {
        logic            present;
        logic            in_range;
        logic            full;
        logic            c_ok;
        logic            c1_ok;
        logic            at_zero;
        logic            rm_move;
        logic            rd_le_now;
        logic            rdb_less;
        logic            child_less;
        logic            par_greater;
        logic            cnt_zero;
        logic            out_free;
        logic            moved;
        logic [OP_W-1:0] op;
    } t_stat;

endpackage

`default_nettype wire

// ----- rtl/core/keyed_min_heap_timer_queue_unit.sv -----
// ----------------------------------------------------------------------------
// keyed_min_heap_timer_queue_unit
// Keyed binary min-heap timer queue with add, adjust, fire, tick, next, clear.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every request first passes through the id
// lookup (map read, heap read, decision). An add of a new timer then sifts up,
// reading the parent and comparing at each level; a re-time or removal sifts
// down, reading the left and then the right child at each level through the
// single read port of the heap memory, and a removal fetches the last entry
// when it must move into the hole. A tick looks at the root and then does one
// removal for each expired timer. Each result is held in the output register,
// which a consumer can stall.
`default_nettype none

module keyed_min_heap_timer_queue_unit #(
    parameter int CAPACITY = kmh_pkg::CAPACITY_DEF,
    parameter int ID_COUNT = kmh_pkg::ID_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [kmh_pkg::OP_W-1:0]     i_op,
    input  wire logic [kmh_pkg::ID_W-1:0]     i_timer_id,
    input  wire logic [kmh_pkg::TMO_W-1:0]    i_timeout_ms,
    input  wire logic [kmh_pkg::TIME_W-1:0]   i_now_ms,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [kmh_pkg::KIND_W-1:0]        o_kind,
    output logic [kmh_pkg::ID_W-1:0]          o_expired_id,
    output logic signed [kmh_pkg::REM_W-1:0]  o_remaining_ms,
    output logic [kmh_pkg::ST_W-1:0]          o_status,
    output logic                              o_last
);

    kmh_pkg::t_cmd  cmd;
    kmh_pkg::t_stat stat;

    kmh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    kmh_dp #(
        .CAPACITY (CAPACITY),
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_timer_id     (i_timer_id),
        .i_timeout_ms   (i_timeout_ms),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_expired_id   (o_expired_id),
        .o_remaining_ms (o_remaining_ms),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/core/kmh_dp.sv -----
// ----------------------------------------------------------------------------
// kmh_dp
// Timer queue datapath: heap and id map memories, hole and moving entry
// registers, comparators, entry count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmh_dp #(
    parameter int CAPACITY = kmh_pkg::CAPACITY_DEF,
    parameter int ID_COUNT = kmh_pkg::ID_COUNT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire kmh_pkg::t_cmd                     i_cmd,
    output kmh_pkg::t_stat                         o_stat,
    input  wire logic [kmh_pkg::OP_W-1:0]          i_op,
    input  wire logic [kmh_pkg::ID_W-1:0]          i_timer_id,
    input  wire logic [kmh_pkg::TMO_W-1:0]         i_timeout_ms,
    input  wire logic [kmh_pkg::TIME_W-1:0]        i_now_ms,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [kmh_pkg::KIND_W-1:0]             o_kind,
    output logic [kmh_pkg::ID_W-1:0]               o_expired_id,
    output logic signed [kmh_pkg::REM_W-1:0]       o_remaining_ms,
    output logic [kmh_pkg::ST_W-1:0]               o_status,
    output logic                                   o_last
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IX_W   = SLOT_W + 2;
    localparam int MAP_AW = $clog2(ID_COUNT);
    localparam int TW     = kmh_pkg::TIME_W;
    localparam int IW     = kmh_pkg::ID_W;
    localparam int EW     = TW + IW;

    logic [EW-1:0]     mem_heap [CAPACITY];
    logic [SLOT_W-1:0] mem_map  [ID_COUNT];

    logic [kmh_pkg::OP_W-1:0]  r_op;
    logic [IW-1:0]             r_id;
    logic [kmh_pkg::TMO_W-1:0] r_tmo;
    logic [TW-1:0]             r_now;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [SLOT_W-1:0]         r_at;
    logic [SLOT_W-1:0]         n_at;
    logic [TW-1:0]             r_mov_exp;
    logic [IW-1:0]             r_mov_own;
    logic [TW-1:0]             r_ca_exp;
    logic [IW-1:0]             r_ca_own;
    logic [SLOT_W-1:0]         r_ca_idx;
    logic [TW-1:0]             r_rd_exp;
    logic [IW-1:0]             r_rd_own;
    logic [SLOT_W-1:0]         r_map_q;
    logic                      r_moved;
    logic                      r_out_valid;

    logic [IX_W-1:0]   at_x;
    logic [IX_W-1:0]   cnt_x;
    logic [IX_W-1:0]   c_l;
    logic [IX_W-1:0]   c_r;
    logic [IX_W-1:0]   par;
    logic [IX_W-1:0]   last_ix;
    logic [SLOT_W-1:0] hrd_addr;
    logic [EW-1:0]     hwr_data;
    logic [TW:0]       exp_sum;
    logic [TW-1:0]     new_exp;
    logic [TW-1:0]     diff;
    logic [kmh_pkg::TMO_W-1:0] rem;
    logic              out_free;

    assign at_x    = IX_W'(r_at);
    assign cnt_x   = IX_W'(r_count);
    assign c_l     = (at_x << 1) + IX_W'(1);
    assign c_r     = c_l + IX_W'(1);
    assign par     = (at_x - IX_W'(1)) >> 1;
    assign last_ix = cnt_x - IX_W'(1);

    // Expiry saturates at the top of the 48-bit time range.
    assign exp_sum = {1'b0, r_now} + (TW + 1)'(r_tmo);
    assign new_exp = exp_sum[TW] ? {TW{1'b1}} : exp_sum[TW-1:0];

    assign diff = r_rd_exp - r_now;
    assign rem  = (diff > TW'(kmh_pkg::REM_MAX)) ? kmh_pkg::REM_MAX
                                                : diff[kmh_pkg::TMO_W-1:0];

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        case (i_cmd.hrd_sel)
            kmh_pkg::HRD_SLOT:   hrd_addr = r_map_q;
            kmh_pkg::HRD_LEFT:   hrd_addr = c_l[SLOT_W-1:0];
            kmh_pkg::HRD_RIGHT:  hrd_addr = c_r[SLOT_W-1:0];
            kmh_pkg::HRD_PARENT: hrd_addr = par[SLOT_W-1:0];
            kmh_pkg::HRD_LAST:   hrd_addr = last_ix[SLOT_W-1:0];
            default:             hrd_addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.hwr_sel)
            kmh_pkg::HWR_CHILD: hwr_data = {r_ca_exp, r_ca_own};
            kmh_pkg::HWR_RD:    hwr_data = {r_rd_exp, r_rd_own};
            default:            hwr_data = {r_mov_exp, r_mov_own};
        endcase
    end

    always_comb begin
        case (i_cmd.at_sel)
            kmh_pkg::AT_SLOT:   n_at = r_map_q;
            kmh_pkg::AT_COUNT:  n_at = SLOT_W'(r_count);
            kmh_pkg::AT_CHILD:  n_at = r_ca_idx;
            kmh_pkg::AT_PARENT: n_at = par[SLOT_W-1:0];
            default:            n_at = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            kmh_pkg::CNT_INC: n_count = r_count + CNT_W'(1);
            kmh_pkg::CNT_DEC: n_count = r_count - CNT_W'(1);
            kmh_pkg::CNT_CLR: n_count = '0;
            default:          n_count = r_count;
        endcase
    end

    // Heap memory: one registered read port, one write port at the hole.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hrd_en) begin
            {r_rd_exp, r_rd_own} <= mem_heap[hrd_addr];
        end
        if (i_cmd.hwr_en) begin
            mem_heap[r_at] <= hwr_data;
        end
    end

    // Id map: every entry written to the heap records its slot here.
    always_ff @(posedge i_clk) begin
        r_map_q <= mem_map[MAP_AW'(r_id)];
        if (i_cmd.hwr_en) begin
            mem_map[MAP_AW'(hwr_data[IW-1:0])] <= r_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_op;
            r_id  <= i_timer_id;
            r_tmo <= i_timeout_ms;
            r_now <= i_now_ms;
        end
        if (i_cmd.at_ld) begin
            r_at <= n_at;
        end
        if (i_cmd.mov_ld) begin
            if (i_cmd.mov_sel == kmh_pkg::MOV_RD) begin
                r_mov_exp <= r_rd_exp;
                r_mov_own <= r_rd_own;
            end else begin
                r_mov_exp <= new_exp;
                r_mov_own <= r_id;
            end
        end
        if (i_cmd.ca_ld) begin
            r_ca_exp <= r_rd_exp;
            r_ca_own <= r_rd_own;
            r_ca_idx <= c_l[SLOT_W-1:0];
        end else if (i_cmd.cb_ld) begin
            r_ca_exp <= r_rd_exp;
            r_ca_own <= r_rd_own;
            r_ca_idx <= c_r[SLOT_W-1:0];
        end
        if (i_cmd.moved_clr) begin
            r_moved <= 1'b0;
        end else if (i_cmd.moved_set) begin
            r_moved <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_kind         <= kmh_pkg::KIND_DONE;
            o_expired_id   <= '0;
            o_remaining_ms <= '0;
            o_status       <= '0;
            o_last         <= i_cmd.emit_last;
            case (i_cmd.emit_sel)
                kmh_pkg::EM_ID_REQ: begin
                    o_kind       <= kmh_pkg::KIND_EXPIRED;
                    o_expired_id <= r_id;
                end
                kmh_pkg::EM_ID_RD: begin
                    o_kind       <= kmh_pkg::KIND_EXPIRED;
                    o_expired_id <= r_rd_own;
                end
                kmh_pkg::EM_REM_RD: begin
                    o_kind         <= kmh_pkg::KIND_REMAIN;
                    o_remaining_ms <= {1'b0, rem};
                end
                kmh_pkg::EM_REM_NONE: begin
                    o_kind         <= kmh_pkg::KIND_REMAIN;
                    o_remaining_ms <= '1;
                end
                default: begin
                    o_status <= i_cmd.emit_status;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;

    always_comb begin
        o_stat.in_range    = 32'(r_id) < ID_COUNT;
        o_stat.present     = o_stat.in_range && (IX_W'(r_map_q) < cnt_x)
                             && (r_rd_own == r_id);
        o_stat.full        = cnt_x >= IX_W'(CAPACITY);
        o_stat.c_ok        = c_l < cnt_x;
        o_stat.c1_ok       = c_r < cnt_x;
        o_stat.at_zero     = r_at == '0;
        o_stat.rm_move     = at_x < last_ix;
        o_stat.rd_le_now   = r_rd_exp <= r_now;
        o_stat.rdb_less    = r_rd_exp < r_ca_exp;
        o_stat.child_less  = r_ca_exp < r_mov_exp;
        o_stat.par_greater = r_rd_exp > r_mov_exp;
        o_stat.cnt_zero    = r_count == '0;
        o_stat.out_free    = out_free;
        o_stat.moved       = r_moved;
        o_stat.op          = r_op;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        IX_W'(r_count) <= IX_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result register overwritten before transfer");

    a_write_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hwr_en |-> (at_x < cnt_x))
        else $error("heap write outside the live entries");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/kmh_ctrl.sv -----
// ----------------------------------------------------------------------------
// kmh_ctrl
// Timer queue sequencer: id lookup, dispatch, sift down and up with a moving
// hole, removal, expiry popping and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module kmh_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire kmh_pkg::t_stat i_stat,
    output kmh_pkg::t_cmd       o_cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MAP   = 5'd1;
    localparam logic [4:0] S_HEAP  = 5'd2;
    localparam logic [4:0] S_DISP  = 5'd3;
    localparam logic [4:0] S_FIRE  = 5'd4;
    localparam logic [4:0] S_RM    = 5'd5;
    localparam logic [4:0] S_RM2   = 5'd6;
    localparam logic [4:0] S_SD    = 5'd7;
    localparam logic [4:0] S_SDA   = 5'd8;
    localparam logic [4:0] S_SDB   = 5'd9;
    localparam logic [4:0] S_SDC   = 5'd10;
    localparam logic [4:0] S_SU    = 5'd11;
    localparam logic [4:0] S_SUC   = 5'd12;
    localparam logic [4:0] S_FIN   = 5'd13;
    localparam logic [4:0] S_AFTER = 5'd14;
    localparam logic [4:0] S_TKL   = 5'd15;
    localparam logic [4:0] S_TKC   = 5'd16;
    localparam logic [4:0] S_END   = 5'd17;

    logic [4:0]                r_state;
    logic [4:0]                n_state;
    logic                      r_end_none;
    logic                      n_end_none;
    logic [kmh_pkg::ST_W-1:0]  r_end_st;
    logic [kmh_pkg::ST_W-1:0]  n_end_st;
    logic                      is_tick;

    assign is_tick = (i_stat.op == kmh_pkg::OP_TICK) || (i_stat.op == kmh_pkg::OP_NEXT);
    assign o_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_end_none = r_end_none;
        n_end_st   = r_end_st;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_HEAP;
            end
            S_HEAP: begin
                o_cmd.hrd_en  = 1'b1;
                o_cmd.hrd_sel = kmh_pkg::HRD_SLOT;
                n_state       = S_DISP;
            end
            S_DISP: begin
                n_end_none = 1'b0;
                n_end_st   = kmh_pkg::ST_OK;
                n_state    = S_END;
                case (i_stat.op)
                    kmh_pkg::OP_ADD, kmh_pkg::OP_ADJUST: begin
                        if (i_stat.present) begin
                            // Re-time in place: sift down, then up if it stayed.
                            o_cmd.at_ld     = 1'b1;
                            o_cmd.at_sel    = kmh_pkg::AT_SLOT;
                            o_cmd.mov_ld    = 1'b1;
                            o_cmd.mov_sel   = kmh_pkg::MOV_NEW;
                            o_cmd.moved_clr = 1'b1;
                            n_state         = S_SD;
                        end else if (i_stat.op == kmh_pkg::OP_ADJUST
                                     || !i_stat.in_range) begin
                            n_end_st = kmh_pkg::ST_NO_ID;
                        end else if (i_stat.full) begin
                            n_end_st = kmh_pkg::ST_FULL;
                        end else begin
                            o_cmd.at_ld   = 1'b1;
                            o_cmd.at_sel  = kmh_pkg::AT_COUNT;
                            o_cmd.mov_ld  = 1'b1;
                            o_cmd.mov_sel = kmh_pkg::MOV_NEW;
                            o_cmd.cnt_op  = kmh_pkg::CNT_INC;
                            n_state       = S_SU;
                        end
                    end
                    kmh_pkg::OP_FIRE: begin
                        if (i_stat.present) begin
                            o_cmd.at_ld  = 1'b1;
                            o_cmd.at_sel = kmh_pkg::AT_SLOT;
                            n_state      = S_FIRE;
                        end else begin
                            n_end_st = kmh_pkg::ST_NO_ID;
                        end
                    end
                    kmh_pkg::OP_TICK, kmh_pkg::OP_NEXT: begin
                        n_state = S_TKL;
                    end
                    kmh_pkg::OP_CLEAR: begin
                        o_cmd.cnt_op = kmh_pkg::CNT_CLR;
                    end
                    default: begin
                    end
                endcase
            end
            S_FIRE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = kmh_pkg::EM_ID_REQ;
                    n_state        = S_RM;
                end
            end
            S_RM: begin
                if (i_stat.rm_move) begin
                    o_cmd.hrd_en  = 1'b1;
                    o_cmd.hrd_sel = kmh_pkg::HRD_LAST;
                    n_state       = S_RM2;
                end else begin
                    o_cmd.cnt_op = kmh_pkg::CNT_DEC;
                    n_state      = S_AFTER;
                end
            end
            S_RM2: begin
                o_cmd.mov_ld    = 1'b1;
                o_cmd.mov_sel   = kmh_pkg::MOV_RD;
                o_cmd.cnt_op    = kmh_pkg::CNT_DEC;
                o_cmd.moved_clr = 1'b1;
                n_state         = S_SD;
            end
            S_SD: begin
                if (i_stat.c_ok) begin
                    o_cmd.hrd_en  = 1'b1;
                    o_cmd.hrd_sel = kmh_pkg::HRD_LEFT;
                    n_state       = S_SDA;
                end else begin
                    n_state = i_stat.moved ? S_FIN : S_SU;
                end
            end
            S_SDA: begin
                o_cmd.ca_ld = 1'b1;
                if (i_stat.c1_ok) begin
                    o_cmd.hrd_en  = 1'b1;
                    o_cmd.hrd_sel = kmh_pkg::HRD_RIGHT;
                    n_state       = S_SDB;
                end else begin
                    n_state = S_SDC;
                end
            end
            S_SDB: begin
                // The right child wins only when strictly earlier.
                o_cmd.cb_ld = i_stat.rdb_less;
                n_state     = S_SDC;
            end
            S_SDC: begin
                if (i_stat.child_less) begin
                    o_cmd.hwr_en    = 1'b1;
                    o_cmd.hwr_sel   = kmh_pkg::HWR_CHILD;
                    o_cmd.at_ld     = 1'b1;
                    o_cmd.at_sel    = kmh_pkg::AT_CHILD;
                    o_cmd.moved_set = 1'b1;
                    n_state         = S_SD;
                end else begin
                    n_state = i_stat.moved ? S_FIN : S_SU;
                end
            end
            S_SU: begin
                if (i_stat.at_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.hrd_en  = 1'b1;
                    o_cmd.hrd_sel = kmh_pkg::HRD_PARENT;
                    n_state       = S_SUC;
                end
            end
            S_SUC: begin
                if (i_stat.par_greater) begin
                    o_cmd.hwr_en  = 1'b1;
                    o_cmd.hwr_sel = kmh_pkg::HWR_RD;
                    o_cmd.at_ld   = 1'b1;
                    o_cmd.at_sel  = kmh_pkg::AT_PARENT;
                    n_state       = S_SU;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.hwr_en  = 1'b1;
                o_cmd.hwr_sel = kmh_pkg::HWR_MOV;
                n_state       = S_AFTER;
            end
            S_AFTER: begin
                n_end_none = 1'b0;
                n_end_st   = kmh_pkg::ST_OK;
                n_state    = is_tick ? S_TKL : S_END;
            end
            S_TKL: begin
                if (i_stat.cnt_zero) begin
                    n_end_none = i_stat.op == kmh_pkg::OP_NEXT;
                    n_end_st   = kmh_pkg::ST_OK;
                    n_state    = S_END;
                end else begin
                    o_cmd.hrd_en  = 1'b1;
                    o_cmd.hrd_sel = kmh_pkg::HRD_ROOT;
                    n_state       = S_TKC;
                end
            end
            S_TKC: begin
                if (i_stat.rd_le_now) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = kmh_pkg::EM_ID_RD;
                        o_cmd.at_ld    = 1'b1;
                        o_cmd.at_sel   = kmh_pkg::AT_ZERO;
                        n_state        = S_RM;
                    end
                end else if (i_stat.op == kmh_pkg::OP_NEXT) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_sel  = kmh_pkg::EM_REM_RD;
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    n_end_none = 1'b0;
                    n_end_st   = kmh_pkg::ST_OK;
                    n_state    = S_END;
                end
            end
            S_END: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_sel    = r_end_none ? kmh_pkg::EM_REM_NONE
                                                   : kmh_pkg::EM_STATUS;
                    o_cmd.emit_status = r_end_st;
                    o_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end_none <= n_end_none;
        r_end_st   <= n_end_st;
    end

`ifndef SYNTHESIS
    a_latch_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |-> (r_state == S_IDLE))
        else $error("request captured while busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> (r_state == S_IDLE))
        else $error("closing result did not return to idle");
`endif

endmodule

`default_nettype wire
